>>> rtl/core/blib_pkg.sv
`default_nettype none

package blib_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int POS_W    = 10;
  localparam int FPOS_W   = 6;
  localparam int LENO_W   = 7;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR         = 3'd0,
    REQ_APPEND        = 3'd1,
    REQ_SWAP_REMOVE   = 3'd2,
    REQ_STABLE_REMOVE = 3'd3,
    REQ_FIND_FIRST    = 3'd4,
    REQ_FIND_LAST     = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SWAP_WR,
    ST_SHIFT,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_APPEND,
    OP_FAIL,
    OP_SWAP_RD,
    OP_SWAP_WR,
    OP_SHIFT_INIT,
    OP_SHIFT,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             pos_ok;
    logic             shift_done;
    logic             scan_hit;
    logic             scan_done;
    logic             out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/core/blib_ram.sv
`default_nettype none

module blib_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/core/blib_ctrl.sv
`default_nettype none

module blib_ctrl
  import blib_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat_i.req)
          REQ_SWAP_REMOVE:   state_d = stat_i.pos_ok ? ST_SWAP_WR : ST_DONE;
          REQ_STABLE_REMOVE: state_d = stat_i.pos_ok ? ST_SHIFT : ST_DONE;
          REQ_FIND_FIRST,
          REQ_FIND_LAST:     state_d = ST_SCAN;
          default:           state_d = ST_DONE;
        endcase
      end
      ST_SWAP_WR: state_d = ST_DONE;
      ST_SHIFT: begin
        if (stat_i.shift_done) state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (stat_i.scan_hit || stat_i.scan_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_DECODE: begin
        unique case (stat_i.req)
          REQ_CLEAR:         cmd_o.op = OP_CLEAR;
          REQ_APPEND:        cmd_o.op = OP_APPEND;
          REQ_SWAP_REMOVE:   cmd_o.op = stat_i.pos_ok ? OP_SWAP_RD : OP_FAIL;
          REQ_STABLE_REMOVE: cmd_o.op = stat_i.pos_ok ? OP_SHIFT_INIT : OP_FAIL;
          REQ_FIND_FIRST,
          REQ_FIND_LAST:     cmd_o.op = OP_SCAN_INIT;
          default:           cmd_o.op = OP_FAIL;
        endcase
      end
      ST_SWAP_WR: cmd_o.op = OP_SWAP_WR;
      ST_SHIFT:   cmd_o.op = OP_SHIFT;
      ST_SCAN:    cmd_o.op = OP_SCAN;
      ST_DONE: begin
        if (stat_i.out_free) cmd_o.op = OP_PUBLISH;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("accepted request did not move to decode");

endmodule

`default_nettype wire

>>> rtl/core/blib_dp.sv
`default_nettype none

module blib_dp
  import blib_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic        [REQ_W-1:0]  req_type_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic        [POS_W-1:0]  position_i,
  input  wire cmd_t                     cmd_i,
  output stat_t                         stat_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          success_o,
  output logic                          found_o,
  output logic             [FPOS_W-1:0] found_position_o,
  output logic             [LENO_W-1:0] length_now_o
);

  // Request registers.
  logic        [REQ_W-1:0]  req_q;
  logic signed [DATA_W-1:0] value_q;
  logic        [POS_W-1:0]  pos_q;

  // List state and walk control.
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [ADDR_W-1:0] pidx_q, pidx_d;
  logic              rev_q, rev_d;

  // Result of the request in flight.
  logic              res_ok_q, res_ok_d;
  logic              res_hit_q, res_hit_d;
  logic [ADDR_W-1:0] res_pos_q, res_pos_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic              out_success_q;
  logic              out_found_q;
  logic [ADDR_W-1:0] out_fpos_q;
  logic [LEN_W-1:0]  out_len_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [LEN_W-1:0]  len_m1;
  logic [LEN_W-1:0]  len_p1;
  logic [LEN_W-1:0]  idx_dec;
  logic [LEN_W-1:0]  idx_inc;
  logic [LEN_W-1:0]  pos_p1;
  logic              pos_ok;
  logic              room;
  logic              hit_now;
  logic              shift_issue;
  logic              scan_issue;
  logic              out_free;

  assign len_m1  = len_q - LEN_W'(1);
  assign len_p1  = len_q + LEN_W'(1);
  assign idx_dec = idx_q - LEN_W'(1);
  assign idx_inc = idx_q + LEN_W'(1);
  assign pos_p1  = LEN_W'(pos_q) + LEN_W'(1);
  assign pos_ok  = 32'(pos_q) < 32'(len_q);
  assign room    = 32'(len_q) < CAPACITY;

  // Data read in the previous cycle is on ram_rdata now.
  assign hit_now = pend_q && (ram_rdata == value_q);

  // During a shift len_q already holds the shortened length, so the last
  // source entry sits at index len_q.
  assign shift_issue = (idx_q <= len_q);
  assign scan_issue  = !hit_now && (rev_q ? (idx_q != '0) : (idx_q < len_q));
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.req        = req_q;
    stat_o.pos_ok     = pos_ok;
    stat_o.shift_done = !shift_issue && !pend_q;
    stat_o.scan_hit   = hit_now;
    stat_o.scan_done  = !scan_issue && !pend_q;
    stat_o.out_free   = out_free;
  end

  always_comb begin
    len_d       = len_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    rev_d       = rev_q;
    res_ok_d    = res_ok_q;
    res_hit_d   = res_hit_q;
    res_pos_d   = res_pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = ram_rdata;
    ram_raddr   = '0;
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        pend_d = 1'b0;
      end
      OP_CLEAR: begin
        len_d     = '0;
        res_ok_d  = 1'b1;
        res_hit_d = 1'b0;
        res_pos_d = '0;
      end
      OP_APPEND: begin
        res_ok_d  = room;
        res_hit_d = 1'b0;
        res_pos_d = '0;
        if (room) begin
          ram_we    = 1'b1;
          ram_waddr = len_q[ADDR_W-1:0];
          ram_wdata = value_q;
          len_d     = len_p1;
        end
      end
      OP_FAIL: begin
        res_ok_d  = 1'b0;
        res_hit_d = 1'b0;
        res_pos_d = '0;
      end
      OP_SWAP_RD: begin
        ram_raddr = len_m1[ADDR_W-1:0];
      end
      OP_SWAP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        len_d     = len_m1;
        res_ok_d  = 1'b1;
        res_hit_d = 1'b0;
        res_pos_d = '0;
      end
      OP_SHIFT_INIT: begin
        len_d     = len_m1;
        idx_d     = pos_p1;
        pend_d    = 1'b0;
        res_ok_d  = 1'b1;
        res_hit_d = 1'b0;
        res_pos_d = '0;
      end
      OP_SHIFT: begin
        // Reads run one entry ahead of the write that moves it down.
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pidx_q - ADDR_W'(1);
          ram_wdata = ram_rdata;
        end
        pend_d = shift_issue;
        if (shift_issue) begin
          ram_raddr = idx_q[ADDR_W-1:0];
          pidx_d    = idx_q[ADDR_W-1:0];
          idx_d     = idx_inc;
        end
      end
      OP_SCAN_INIT: begin
        rev_d     = (req_q == REQ_FIND_LAST);
        idx_d     = (req_q == REQ_FIND_LAST) ? len_q : '0;
        pend_d    = 1'b0;
        res_ok_d  = 1'b0;
        res_hit_d = 1'b0;
        res_pos_d = '0;
      end
      OP_SCAN: begin
        if (hit_now) begin
          res_hit_d = 1'b1;
          res_pos_d = pidx_q;
        end
        pend_d = scan_issue;
        if (scan_issue) begin
          if (rev_q) begin
            ram_raddr = idx_dec[ADDR_W-1:0];
            pidx_d    = idx_dec[ADDR_W-1:0];
            idx_d     = idx_dec;
          end else begin
            ram_raddr = idx_q[ADDR_W-1:0];
            pidx_d    = idx_q[ADDR_W-1:0];
            idx_d     = idx_inc;
          end
        end
      end
      OP_PUBLISH: begin
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      req_q   <= req_type_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
    idx_q     <= idx_d;
    pidx_q    <= pidx_d;
    rev_q     <= rev_d;
    res_ok_q  <= res_ok_d;
    res_hit_q <= res_hit_d;
    res_pos_q <= res_pos_d;
    if (cmd_i.op == OP_PUBLISH) begin
      out_success_q <= res_ok_q;
      out_found_q   <= res_hit_q;
      out_fpos_q    <= res_pos_q;
      out_len_q     <= len_q;
    end
  end

  blib_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign success_o        = out_success_q;
  assign found_o          = out_found_q;
  assign found_position_o = FPOS_W'(out_fpos_q);
  assign length_now_o     = LENO_W'(out_len_q);

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(len_q) <= CAPACITY)
    else $error("list length above capacity");

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_PUBLISH) |-> out_free)
    else $error("result published over one not yet taken");

  a_shift_ports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SHIFT && ram_we && shift_issue) |-> (ram_waddr != ram_raddr))
    else $error("shift reads and writes the same entry");

endmodule

`default_nettype wire

>>> rtl/core/bounded_integer_list_buffer.sv
// Bounded list of up to CAPACITY signed 32-bit words with a current length.
// Requests arrive on the in channel (in_valid_i/in_ready_o) carrying
// req_type_i, value_i and position_i; every request gives exactly one result
// on the out channel (out_valid_o/out_ready_i) with success_o, found_o,
// found_position_o and length_now_o, in request order.
// One request is worked on at a time; in_ready_o is high only while idle.
// Clear, append, a failed removal and an unused code finish at decode;
// swap remove reads the last entry and writes it over position p; stable
// remove moves each entry after p down by one; find first / find last
// compare entries from the front / back, stopping early on a match.
// These walks run on the single entry memory, one read per cycle with a
// registered read, streamed one entry ahead of the compare or write.
// The finished result sits in an output register; a stall on out_ready_i
// holds it, and the next request may be accepted and worked on meanwhile,
// waiting at its end until the register frees.
// Reset empties the list and drops any pending result; the entry memory is
// not cleared, since only entries below the length are ever read.
`default_nettype none

module bounded_integer_list_buffer
  import blib_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic        [REQ_W-1:0]  req_type_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire logic        [POS_W-1:0]  position_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          success_o,
  output logic                          found_o,
  output logic             [FPOS_W-1:0] found_position_o,
  output logic             [LENO_W-1:0] length_now_o
);

  cmd_t  cmd;
  stat_t stat;

  blib_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  blib_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_type_i      (req_type_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .success_o       (success_o),
    .found_o         (found_o),
    .found_position_o(found_position_o),
    .length_now_o    (length_now_o)
  );

endmodule

`default_nettype wire

>>> test/blib_list_checker.sv
module blib_list_checker
  import blib_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [DATA_W-1:0]   value_i,
  input  logic [POS_W-1:0]    position_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                success_i,
  input  logic                found_i,
  input  logic [FPOS_W-1:0]   found_position_i,
  input  logic [LENO_W-1:0]   length_now_i,
  output int                  fail_count_o,
  output int                  results_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              success;
    logic              found;
    logic [FPOS_W-1:0] fpos;
    logic [LENO_W-1:0] len;
  } list_result_t;

  logic [DATA_W-1:0] stored_words [CAPACITY];
  int unsigned       stored_len = 0;
  list_result_t      pending_results [$];
  int                mismatches = 0;
  int                waiting = 0;

  assign fail_count_o  = mismatches;
  assign results_due_o = waiting;

  // Applies one request to the shadow list and returns what the block must report.
  function automatic list_result_t apply_request(input logic [REQ_W-1:0]  req,
                                                 input logic [DATA_W-1:0] val,
                                                 input logic [POS_W-1:0]  pos);
    list_result_t res;
    int unsigned  i;
    res = '0;
    case (req)
      REQ_CLEAR: begin
        stored_len  = 0;
        res.success = 1'b1;
      end
      REQ_APPEND: begin
        if (stored_len < CAPACITY) begin
          stored_words[stored_len] = val;
          stored_len++;
          res.success = 1'b1;
        end
      end
      REQ_SWAP_REMOVE: begin
        if (pos < stored_len) begin
          stored_words[pos] = stored_words[stored_len - 1];
          stored_len--;
          res.success = 1'b1;
        end
      end
      REQ_STABLE_REMOVE: begin
        if (pos < stored_len) begin
          stored_len--;
          for (i = 32'(pos); i < stored_len; i++) begin
            stored_words[i] = stored_words[i + 1];
          end
          res.success = 1'b1;
        end
      end
      REQ_FIND_FIRST: begin
        for (i = 0; i < stored_len; i++) begin
          if (stored_words[i] == val) begin
            res.found = 1'b1;
            res.fpos  = i[FPOS_W-1:0];
            break;
          end
        end
      end
      REQ_FIND_LAST: begin
        for (i = stored_len; i > 0; i--) begin
          if (stored_words[i - 1] == val) begin
            res.found = 1'b1;
            res.fpos  = i[FPOS_W-1:0] - 1'b1;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    res.len = stored_len[LENO_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      pending_results.delete();
      stored_len = 0;
      waiting    = 0;
    end else begin
      // A result can never belong to a request taken at the same edge, so
      // results are matched before new requests are queued.
      if (out_valid_i && out_ready_i) begin
        got = '{success_i, found_i, found_position_i, length_now_i};
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.success !== want.success) begin
            $error("success: expected %0d, got %0d", want.success, got.success);
            mismatches++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatches++;
          end
          if (got.fpos !== want.fpos) begin
            $error("found_position: expected %0d, got %0d", want.fpos, got.fpos);
            mismatches++;
          end
          if (got.len !== want.len) begin
            $error("length_now: expected %0d, got %0d", want.len, got.len);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.push_back(apply_request(req_type_i, value_i, position_i));
      end
      waiting = pending_results.size();
    end
  end

endmodule

>>> test/bounded_integer_list_buffer_tb.sv
module bounded_integer_list_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import blib_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;
  localparam logic [POS_W-1:0] POS_MAX     = '1;
  localparam int               LONG_HOLD   = 300;
  localparam int               PHASE_ITEMS = 420;
  localparam int               BURST_ITEMS = 24;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic        [REQ_W-1:0]  req_type_i  = '0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic        [POS_W-1:0]  position_i  = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     success_o;
  logic                     found_o;
  logic        [FPOS_W-1:0] found_position_o;
  logic        [LENO_W-1:0] length_now_o;

  int fail_count;
  int results_due;

  // Stimulus-side view of the list length, used to aim positions and to end the fill.
  int unsigned       list_len       = 0;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                hold_asks      = 0;
  int                hold_served    = 0;
  int                hold_left      = 0;
  logic [DATA_W-1:0] value_pool [8];

  int phase_send_idle  [4] = '{0, 82, 0, 15};
  int phase_recv_stall [4] = '{0, 0, 82, 15};
  int phase_append_mix [4] = '{40, 45, 40, 50};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bounded_integer_list_buffer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .success_o        (success_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .length_now_o     (length_now_o)
  );

  blib_list_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .req_type_i       (req_type_i),
    .value_i          (value_i),
    .position_i       (position_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .success_i        (success_o),
    .found_i          (found_o),
    .found_position_i (found_position_o),
    .length_now_i     (length_now_o),
    .fail_count_o     (fail_count),
    .results_due_o    (results_due)
  );

  // Receiver: random stalls, or a long hold-off whenever the stimulus asks for one.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left   <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(input logic [REQ_W-1:0]  req,
                              input logic [DATA_W-1:0] val,
                              input logic [POS_W-1:0]  pos);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    case (req)
      REQ_CLEAR: list_len = 0;
      REQ_APPEND: if (list_len < CAPACITY) list_len++;
      REQ_SWAP_REMOVE, REQ_STABLE_REMOVE: if (pos < list_len) list_len--;
      default: begin
      end
    endcase
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(1) != 0) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  task automatic random_request(input int append_pct);
    int                r;
    logic [REQ_W-1:0]  req;
    logic [POS_W-1:0]  pos;
    r = $urandom_range(99);
    if (r < 2) begin
      req = REQ_CLEAR;
    end else if (r < 4) begin
      req = ($urandom_range(1) != 0) ? REQ_SPARE_7 : REQ_SPARE_6;
    end else if (r < 4 + append_pct) begin
      req = REQ_APPEND;
    end else begin
      case ($urandom_range(3))
        0: req = REQ_SWAP_REMOVE;
        1: req = REQ_STABLE_REMOVE;
        2: req = REQ_FIND_FIRST;
        default: req = REQ_FIND_LAST;
      endcase
    end
    if (list_len > 0 && $urandom_range(99) < 75) begin
      pos = POS_W'($urandom_range(list_len - 1));
    end else begin
      pos = POS_W'($urandom_range(POS_MAX));
    end
    send_request(req, pick_value(), pos);
  endtask

  initial begin
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int k = 4; k < 8; k++) value_pool[k] = $urandom;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty list, extreme words, duplicates, failed and edge removals.
    send_request(REQ_CLEAR, 32'h0, '0);
    send_request(REQ_FIND_FIRST, 32'h0, '0);
    send_request(REQ_FIND_LAST, 32'h0, '0);
    send_request(REQ_SWAP_REMOVE, 32'h0, '0);
    send_request(REQ_STABLE_REMOVE, 32'h0, '0);
    send_request(REQ_APPEND, 32'h7fff_ffff, '0);
    send_request(REQ_APPEND, 32'h8000_0000, POS_MAX);
    send_request(REQ_APPEND, 32'h0000_0000, '0);
    send_request(REQ_APPEND, 32'hffff_ffff, '0);
    send_request(REQ_APPEND, 32'h8000_0000, '0);
    send_request(REQ_FIND_FIRST, 32'h8000_0000, '0);
    send_request(REQ_FIND_LAST, 32'h8000_0000, '0);
    send_request(REQ_FIND_FIRST, 32'h7fff_ffff, '0);
    send_request(REQ_FIND_LAST, 32'h1234_5678, '0);
    send_request(REQ_SWAP_REMOVE, 32'h0, 10'd5);
    send_request(REQ_STABLE_REMOVE, 32'h0, POS_MAX);
    send_request(REQ_STABLE_REMOVE, 32'h0, 10'd1);
    send_request(REQ_SWAP_REMOVE, 32'h0, 10'd3);
    send_request(REQ_SWAP_REMOVE, 32'h0, 10'd0);
    send_request(REQ_SPARE_6, 32'hffff_ffff, POS_MAX);
    send_request(REQ_SPARE_7, 32'h0, '0);
    send_request(REQ_FIND_FIRST, 32'hffff_ffff, '0);
    send_request(REQ_CLEAR, 32'hffff_ffff, POS_MAX);
    send_request(REQ_APPEND, 32'h5a5a_a5a5, '0);
    send_request(REQ_STABLE_REMOVE, 32'h0, '0);
    wait_for_results();

    // Fill the list to capacity, push past it, walk the full list, then remove near the ends.
    while (list_len < CAPACITY) begin
      send_request(REQ_APPEND, pick_value(), POS_W'($urandom_range(POS_MAX)));
    end
    repeat (3) send_request(REQ_APPEND, pick_value(), '0);
    repeat (8) begin
      send_request(REQ_FIND_FIRST, pick_value(), '0);
      send_request(REQ_FIND_LAST, pick_value(), '0);
    end
    send_request(REQ_STABLE_REMOVE, 32'h0, '0);
    send_request(REQ_SWAP_REMOVE, 32'h0, 10'd62);
    send_request(REQ_STABLE_REMOVE, 32'h0, 10'd62);
    wait_for_results();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send_idle[p];
      recv_stall_pct <= phase_recv_stall[p];
      repeat (PHASE_ITEMS) random_request(phase_append_mix[p]);
      if (p == 0) begin
        // The receiver holds off while requests keep coming, so the block backs up.
        hold_asks <= hold_asks + 1;
        repeat (BURST_ITEMS) random_request(phase_append_mix[p]);
      end
      wait_for_results();
    end

    repeat (4 * CAPACITY) @(posedge clk_i);
    if (fail_count == 0 && results_due == 0) begin
      $display("** bounded_integer_list_buffer: PASSED **");
    end else begin
      $display("** bounded_integer_list_buffer: FAILED **");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("** bounded_integer_list_buffer: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/blib_pkg.sv
rtl/core/blib_ram.sv
rtl/core/blib_ctrl.sv
rtl/core/blib_dp.sv
rtl/core/bounded_integer_list_buffer.sv
test/blib_list_checker.sv
test/bounded_integer_list_buffer_tb.sv
